// ===== sv/assert_macros.svh =====
// Assertion macros shared by the core and top-level RTL files of the indicator block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Implication checked at every rising edge, disabled while reset is low.
`define ASSERT_CLK(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed: label");
// Condition that must hold at every rising edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("assertion failed: label");
`else
`define ASSERT_CLK(label, clk, rst_n, prop)
`define ASSERT_ALWAYS(label, clk, rst_n, cond)
`endif
`endif

// ===== sv/ipl_pkg.sv =====
// Package with the item types, register codes and reset values of the indicator block.
package ipl_pkg;

    localparam int unsigned CfgIndexWidth = 3;
    localparam int unsigned CfgDataWidth  = 16;

    localparam logic [7:0]  WarmThresholdReset = 8'd70;
    localparam logic [7:0]  ColdThresholdReset = 8'd60;
    localparam logic [15:0] CooldownTicksReset = 16'd100;
    localparam logic [7:0]  BrightStepReset    = 8'd1;
    localparam logic [7:0]  BrightMaxReset     = 8'd255;

    typedef enum logic [CfgIndexWidth-1:0] {
        CFG_WARM_THRESHOLD = 3'd0,
        CFG_COLD_THRESHOLD = 3'd1,
        CFG_COOLDOWN_TICKS = 3'd2,
        CFG_BRIGHT_STEP    = 3'd3,
        CFG_BRIGHT_MAX     = 3'd4
    } t_cfg_index;

    typedef struct packed {
        logic [7:0] temperature;
        logic       cam_switch;
        logic       run_normal;
    } t_in_item;

    typedef struct packed {
        logic       warm_pulse;
        logic       cam_pulse;
        logic [7:0] green_level;
        logic [7:0] blue_level;
    } t_out_item;

    typedef struct packed {
        logic [7:0]  warm_threshold;
        logic [7:0]  cold_threshold;
        logic [15:0] cooldown_ticks;
        logic [7:0]  bright_step;
        logic [7:0]  bright_max;
    } t_cfg;

endpackage

// ===== sv/ipl_cfg.sv =====
// Configuration register file of the indicator block.
module ipl_cfg (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_valid,
    input  logic [ipl_pkg::CfgIndexWidth-1:0]   i_cfg_index,
    input  logic [ipl_pkg::CfgDataWidth-1:0]    i_cfg_data,
    output logic                                o_cfg_ready,
    output ipl_pkg::t_cfg                       o_cfg
);

    ipl_pkg::t_cfg r_cfg;
    ipl_pkg::t_cfg n_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            case (ipl_pkg::t_cfg_index'(i_cfg_index))
                ipl_pkg::CFG_WARM_THRESHOLD: n_cfg.warm_threshold = i_cfg_data[7:0];
                ipl_pkg::CFG_COLD_THRESHOLD: n_cfg.cold_threshold = i_cfg_data[7:0];
                ipl_pkg::CFG_COOLDOWN_TICKS: n_cfg.cooldown_ticks = i_cfg_data;
                ipl_pkg::CFG_BRIGHT_STEP:    n_cfg.bright_step    = i_cfg_data[7:0];
                ipl_pkg::CFG_BRIGHT_MAX:     n_cfg.bright_max     = i_cfg_data[7:0];
                default:                     n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.warm_threshold <= ipl_pkg::WarmThresholdReset;
            r_cfg.cold_threshold <= ipl_pkg::ColdThresholdReset;
            r_cfg.cooldown_ticks <= ipl_pkg::CooldownTicksReset;
            r_cfg.bright_step    <= ipl_pkg::BrightStepReset;
            r_cfg.bright_max     <= ipl_pkg::BrightMaxReset;
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule

// ===== sv/ipl_core.sv =====
// Tick state of the indicator block: hysteresis, cam edge with cooldown, and ramps.
`include "assert_macros.svh"

module ipl_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_step,
    input  ipl_pkg::t_in_item   i_item,
    input  ipl_pkg::t_cfg       i_cfg,
    output ipl_pkg::t_out_item  o_result
);

    logic        r_warm;
    logic        r_cam_prev;
    logic [15:0] r_count;
    logic [7:0]  r_green;
    logic [7:0]  r_blue;
    logic        r_wp;
    logic        r_cp;

    logic        n_warm;
    logic        n_cam_prev;
    logic [15:0] n_count;
    logic [7:0]  n_green;
    logic [7:0]  n_blue;
    logic        n_wp;
    logic        n_cp;

    function automatic logic [7:0] ramp_up(input logic [7:0] level,
                                           input logic [7:0] step,
                                           input logic [7:0] max_level);
        logic [8:0] sum;
        sum = {1'b0, level} + {1'b0, step};
        if (level >= max_level || sum > {1'b0, max_level}) begin
            return max_level;
        end
        return sum[7:0];
    endfunction

    function automatic logic [7:0] ramp_down(input logic [7:0] level,
                                             input logic [7:0] step);
        return (level > step) ? (level - step) : 8'd0;
    endfunction

    always_comb begin
        n_warm     = r_warm;
        n_cam_prev = r_cam_prev;
        n_count    = r_count;
        n_green    = r_green;
        n_blue     = r_blue;
        n_wp       = r_wp;
        n_cp       = r_cp;
        if (i_item.run_normal) begin
            if (!r_warm) begin
                if (i_item.temperature >= i_cfg.warm_threshold) begin
                    n_warm = 1'b1;
                    n_wp   = 1'b1;
                end
            end else begin
                n_wp = 1'b0;
                if (i_item.temperature <= i_cfg.cold_threshold) begin
                    n_warm = 1'b0;
                end
            end

            n_cp = 1'b0;
            if (r_count >= i_cfg.cooldown_ticks) begin
                if (i_item.cam_switch && !r_cam_prev) begin
                    n_cp    = 1'b1;
                    n_count = '0;
                end
            end else begin
                n_count = r_count + 16'd1;
            end
            n_cam_prev = i_item.cam_switch;

            if (!n_warm || i_item.cam_switch) begin
                n_green = ramp_down(r_green, i_cfg.bright_step);
            end else begin
                n_green = ramp_up(r_green, i_cfg.bright_step, i_cfg.bright_max);
            end

            if (i_item.cam_switch) begin
                n_blue = ramp_up(r_blue, i_cfg.bright_step, i_cfg.bright_max);
            end else begin
                n_blue = ramp_down(r_blue, i_cfg.bright_step);
            end
        end
    end

    always_comb begin
        o_result.warm_pulse  = n_wp;
        o_result.cam_pulse   = n_cp;
        o_result.green_level = n_green;
        o_result.blue_level  = n_blue;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_warm     <= 1'b0;
            r_cam_prev <= 1'b0;
            r_count    <= ipl_pkg::CooldownTicksReset;
            r_green    <= '0;
            r_blue     <= '0;
            r_wp       <= 1'b0;
            r_cp       <= 1'b0;
        end else if (i_step) begin
            r_warm     <= n_warm;
            r_cam_prev <= n_cam_prev;
            r_count    <= n_count;
            r_green    <= n_green;
            r_blue     <= n_blue;
            r_wp       <= n_wp;
            r_cp       <= n_cp;
        end
    end

    // A warm pulse is only ever raised together with the warm state.
    `ASSERT_ALWAYS(a_pulse_implies_warm, i_clk, i_rst_n, (!r_wp || r_warm))
    // A cam pulse restarts the cooldown count.
    `ASSERT_CLK(a_cam_restarts_count, i_clk, i_rst_n, (i_step && n_cp) |=> (r_count == '0))
    // Hold mode leaves every state element untouched.
    `ASSERT_CLK(a_hold_keeps_state, i_clk, i_rst_n, (i_step && !i_item.run_normal) |=> ($stable(r_green) && $stable(r_blue) && $stable(r_warm) && $stable(r_count)))
    // State moves only when an item is processed.
    `ASSERT_CLK(a_idle_keeps_count, i_clk, i_rst_n, (!i_step) |=> ($stable(r_count) && $stable(r_cam_prev)))

endmodule

// ===== sv/indicator_pulse_and_led_ramp.sv =====
// Top level of the indicator block: handshakes, item register and result register.
// Each item is one tick of a temperature hysteresis with a warm pulse, a cam-switch
// edge detector with a cooldown count, and two saturating brightness ramps (green
// and blue). The block takes one item per clock cycle for as long as results are
// taken: an item waits in the input register, its tick is evaluated there by a
// single pass of compares, 9-bit ramp adds and a 16-bit count increment against the
// stored state, and its result is written into the output register in the same
// cycle the state updates. While the result register holds an untaken result the
// input register still accepts one more item; after that o_in_ready drops until
// the output side takes its result. Configuration writes are accepted in every
// cycle and should only be made while no item is in flight.
`include "assert_macros.svh"

module indicator_pulse_and_led_ramp (
    input  logic                                i_clk,
    input  logic                                i_rst_n,

    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  ipl_pkg::t_in_item                   i_in,

    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output ipl_pkg::t_out_item                  o_out,

    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [ipl_pkg::CfgIndexWidth-1:0]   i_cfg_index,
    input  logic [ipl_pkg::CfgDataWidth-1:0]    i_cfg_data
);

    ipl_pkg::t_cfg      cfg;
    ipl_pkg::t_out_item result;

    logic               r_in_valid;
    ipl_pkg::t_in_item  r_in;
    logic               r_out_valid;
    ipl_pkg::t_out_item r_out;

    logic               advance;

    // The item in the input register moves on when the result register is
    // empty or its result is being taken in this cycle.
    assign advance    = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    ipl_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg_ready (o_cfg_ready),
        .o_cfg       (cfg)
    );

    ipl_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (advance),
        .i_item   (r_in),
        .i_cfg    (cfg),
        .o_result (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in <= i_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= result;
        end
    end

    // An item never leaves the input register into a full, stalled result register.
    `ASSERT_ALWAYS(a_no_overwrite, i_clk, i_rst_n, (!advance || !r_out_valid || i_out_ready))
    // Every processed item shows up as a valid result in the next cycle.
    `ASSERT_CLK(a_step_gives_result, i_clk, i_rst_n, advance |=> r_out_valid)
    // A stalled input register keeps its item.
    `ASSERT_CLK(a_item_held, i_clk, i_rst_n, (r_in_valid && !advance) |=> (r_in_valid && $stable(r_in)))

endmodule

// ===== tb/indicator_checker.sv =====
`timescale 1ns / 1ps
// Checker for the indicator block: predicts each result from accepted items and compares.
module indicator_checker (
    input  logic                               i_clk,
    input  logic                               i_rst_n,

    input  logic                               i_in_valid,
    input  logic                               i_in_ready,
    input  ipl_pkg::t_in_item                  i_in,

    input  logic                               i_out_valid,
    input  logic                               i_out_ready,
    input  ipl_pkg::t_out_item                 i_out,

    input  logic                               i_cfg_valid,
    input  logic                               i_cfg_ready,
    input  logic [ipl_pkg::CfgIndexWidth-1:0]  i_cfg_index,
    input  logic [ipl_pkg::CfgDataWidth-1:0]   i_cfg_data,

    output int                                 o_pending,
    output int                                 o_mismatches
);

    localparam int ReportLimit = 10;

    ipl_pkg::t_cfg      setting;
    logic               warm_flag;
    logic               cam_prev;
    logic               warm_pulse;
    logic               cam_pulse;
    logic [15:0]        cooldown_count;
    logic [7:0]         green;
    logic [7:0]         blue;

    ipl_pkg::t_out_item indications_due[$];
    int                 mismatch_count = 0;

    function automatic logic [7:0] raise_level(input logic [7:0] level);
        logic [8:0] sum;
        if (level >= setting.bright_max) begin
            return setting.bright_max;
        end
        sum = {1'b0, level} + {1'b0, setting.bright_step};
        return (sum > {1'b0, setting.bright_max}) ? setting.bright_max : sum[7:0];
    endfunction

    function automatic logic [7:0] lower_level(input logic [7:0] level);
        return (level > setting.bright_step) ? level - setting.bright_step : 8'd0;
    endfunction

    // Advances the tracked state by one tick and returns the indications it shows.
    function automatic ipl_pkg::t_out_item step_indicator(input ipl_pkg::t_in_item it);
        ipl_pkg::t_out_item res;
        if (it.run_normal) begin
            if (!warm_flag) begin
                if (it.temperature >= setting.warm_threshold) begin
                    warm_flag  = 1'b1;
                    warm_pulse = 1'b1;
                end
            end else begin
                warm_pulse = 1'b0;
                if (it.temperature <= setting.cold_threshold) begin
                    warm_flag = 1'b0;
                end
            end

            cam_pulse = 1'b0;
            if (cooldown_count >= setting.cooldown_ticks) begin
                if (it.cam_switch && !cam_prev) begin
                    cam_pulse      = 1'b1;
                    cooldown_count = 16'd0;
                end
            end else begin
                cooldown_count = cooldown_count + 16'd1;
            end
            cam_prev = it.cam_switch;

            green = (!warm_flag || it.cam_switch) ? lower_level(green) : raise_level(green);
            blue  = it.cam_switch ? raise_level(blue) : lower_level(blue);
        end
        res.warm_pulse  = warm_pulse;
        res.cam_pulse   = cam_pulse;
        res.green_level = green;
        res.blue_level  = blue;
        return res;
    endfunction

    task automatic check_field(input string field, input int want, input int got);
        if (want != got) begin
            mismatch_count++;
            if (mismatch_count <= ReportLimit) begin
                $display("%0t: %s expected %0d, got %0d", $time, field, want, got);
            end
        end
    endtask

    always @(posedge i_clk) begin
        ipl_pkg::t_out_item want;
        if (!i_rst_n) begin
            setting        = '{ipl_pkg::WarmThresholdReset, ipl_pkg::ColdThresholdReset,
                               ipl_pkg::CooldownTicksReset, ipl_pkg::BrightStepReset,
                               ipl_pkg::BrightMaxReset};
            warm_flag      = 1'b0;
            cam_prev       = 1'b0;
            warm_pulse     = 1'b0;
            cam_pulse      = 1'b0;
            cooldown_count = ipl_pkg::CooldownTicksReset;
            green          = 8'd0;
            blue           = 8'd0;
            indications_due.delete();
        end else begin
            // Results leave before a new item is predicted in the same cycle.
            if (i_out_valid && i_out_ready) begin
                if (indications_due.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= ReportLimit) begin
                        $display("%0t: result arrived with nothing expected", $time);
                    end
                end else begin
                    want = indications_due.pop_front();
                    check_field("warm_pulse", want.warm_pulse, i_out.warm_pulse);
                    check_field("cam_pulse", want.cam_pulse, i_out.cam_pulse);
                    check_field("green_level", want.green_level, i_out.green_level);
                    check_field("blue_level", want.blue_level, i_out.blue_level);
                end
            end

            if (i_cfg_valid && i_cfg_ready) begin
                case (ipl_pkg::t_cfg_index'(i_cfg_index))
                    ipl_pkg::CFG_WARM_THRESHOLD: setting.warm_threshold = i_cfg_data[7:0];
                    ipl_pkg::CFG_COLD_THRESHOLD: setting.cold_threshold = i_cfg_data[7:0];
                    ipl_pkg::CFG_COOLDOWN_TICKS: setting.cooldown_ticks = i_cfg_data;
                    ipl_pkg::CFG_BRIGHT_STEP:    setting.bright_step    = i_cfg_data[7:0];
                    ipl_pkg::CFG_BRIGHT_MAX:     setting.bright_max     = i_cfg_data[7:0];
                    default: ;
                endcase
            end

            if (i_in_valid && i_in_ready) begin
                indications_due.push_back(step_indicator(i_in));
            end
        end
        o_pending    <= indications_due.size();
        o_mismatches <= mismatch_count;
    end

endmodule

// ===== tb/tb_indicator_pulse_and_led_ramp.sv =====
`timescale 1ns / 1ps
// Testbench top: drives ticks and register writes into the indicator block and gives the verdict.
module tb_indicator_pulse_and_led_ramp;

    // The run is short; the cycle limit is many times the slowest correct run.
    localparam int unsigned CycleLimit  = 400000;
    localparam int unsigned IdlePercent = 17;
    localparam int unsigned PhaseTicks  = 100;
    localparam int unsigned PhaseCount  = 8;
    localparam int unsigned SteadyPhase = 3;

    logic                               clk       = 1'b0;
    logic                               rst_n     = 1'b0;

    logic                               in_valid  = 1'b0;
    logic                               in_ready;
    ipl_pkg::t_in_item                  in_item   = '0;

    logic                               out_valid;
    logic                               out_ready = 1'b0;
    ipl_pkg::t_out_item                 out_item;

    logic                               cfg_valid = 1'b0;
    logic                               cfg_ready;
    logic [ipl_pkg::CfgIndexWidth-1:0]  cfg_index = '0;
    logic [ipl_pkg::CfgDataWidth-1:0]   cfg_data  = '0;

    // While steady is set neither side idles at random, so the block runs at full rate.
    logic                               steady    = 1'b0;
    int unsigned                        cycles    = 0;
    int                                 pending;
    int                                 mismatches;

    // Thresholds currently programmed; temperatures are aimed around them so the
    // hysteresis actually switches back and forth.
    logic [7:0]                         warm_set  = ipl_pkg::WarmThresholdReset;
    logic [7:0]                         cold_set  = ipl_pkg::ColdThresholdReset;

    indicator_pulse_and_led_ramp u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in        (in_item),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out       (out_item),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    indicator_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_in         (in_item),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_out        (out_item),
        .i_cfg_valid  (cfg_valid),
        .i_cfg_ready  (cfg_ready),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .o_pending    (pending),
        .o_mismatches (mismatches)
    );

    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // The result side stalls at random, except during the steady stretch.
    always @(negedge clk) begin
        out_ready <= steady ? 1'b1 : ($urandom_range(99) >= IdlePercent);
    end

    // Guard against a hung handshake or results that never arrive.
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles >= CycleLimit) begin
            $display("tb_indicator_pulse_and_led_ramp: errors");
            $finish;
        end
    end

    // Offers one tick and returns at the falling edge after it was taken. Valid stays
    // high across back-to-back items; in this task it only drops for a random gap.
    task automatic send_tick(input logic [7:0] temp, input logic cam, input logic run);
        while (!steady && $urandom_range(99) < IdlePercent) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= '{temperature: temp, cam_switch: cam, run_normal: run};
        do @(posedge clk); while (!in_ready);
        @(negedge clk);
    endtask

    // Stops sending and waits until every predicted result has been taken. It always
    // waits on the clock before it checks, so the valid never drops and rises in the same step.
    task automatic settle();
        in_valid <= 1'b0;
        do @(negedge clk); while (pending != 0);
    endtask

    task automatic write_reg(input logic [ipl_pkg::CfgIndexWidth-1:0] idx,
                             input logic [ipl_pkg::CfgDataWidth-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
    endtask

    // Writes every register from an idle block. The 8-bit registers get junk in the
    // upper data bits, which must be dropped. Optionally the unused indexes are hit
    // too; those writes must change nothing.
    task automatic load_settings(input ipl_pkg::t_cfg c, input bit stray);
        settle();
        write_reg(ipl_pkg::CFG_WARM_THRESHOLD, {8'($urandom), c.warm_threshold});
        write_reg(ipl_pkg::CFG_COLD_THRESHOLD, {8'($urandom), c.cold_threshold});
        write_reg(ipl_pkg::CFG_COOLDOWN_TICKS, c.cooldown_ticks);
        write_reg(ipl_pkg::CFG_BRIGHT_STEP, {8'($urandom), c.bright_step});
        write_reg(ipl_pkg::CFG_BRIGHT_MAX, {8'($urandom), c.bright_max});
        if (stray) begin
            for (int k = int'(ipl_pkg::CFG_BRIGHT_MAX) + 1;
                 k < (1 << ipl_pkg::CfgIndexWidth); k++) begin
                write_reg(ipl_pkg::CfgIndexWidth'(k), ipl_pkg::CfgDataWidth'($urandom));
            end
        end
        cfg_valid <= 1'b0;
        warm_set = c.warm_threshold;
        cold_set = c.cold_threshold;
    endtask

    function automatic logic [7:0] near(input logic [7:0] center);
        int v;
        v = int'(center) + int'($urandom_range(8)) - 4;
        if (v < 0) v = 0;
        if (v > 255) v = 255;
        return 8'(v);
    endfunction

    // Mostly sane settings: cold at or below warm and a short cooldown so cam pulses come
    // often, with occasional inverted thresholds, long cooldowns and big steps.
    function automatic ipl_pkg::t_cfg random_setting();
        ipl_pkg::t_cfg c;
        c.warm_threshold = 8'($urandom_range(20, 235));
        c.cold_threshold = ($urandom_range(9) == 0) ? 8'($urandom)
                         : c.warm_threshold - 8'($urandom_range(20));
        c.cooldown_ticks = ($urandom_range(4) == 0) ? 16'($urandom_range(30, 400))
                         : 16'($urandom_range(12));
        c.bright_step    = ($urandom_range(3) == 0) ? 8'($urandom_range(1, 255))
                         : 8'($urandom_range(1, 16));
        c.bright_max     = 8'($urandom_range(255));
        return c;
    endfunction

    initial begin
        ipl_pkg::t_cfg c;
        logic          cam_level;
        logic [7:0]    temp;
        int unsigned   pick;

        cam_level = 1'b0;
        repeat (3) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed ticks under the reset settings. A held tick comes first, before
        // anything was processed.
        send_tick(8'd0, 1'b0, 1'b0);
        send_tick(8'd69, 1'b0, 1'b1);            // one below the warm threshold
        send_tick(8'd70, 1'b0, 1'b1);            // exactly at it: warm pulse
        send_tick(8'd255, 1'b1, 1'b0);           // hold mode repeats the pulse
        send_tick(8'd255, 1'b0, 1'b1);           // pulse clears, green climbs
        send_tick(8'd61, 1'b1, 1'b1);            // cam edge with a full cooldown
        send_tick(8'd61, 1'b0, 1'b1);
        send_tick(8'd61, 1'b1, 1'b1);            // edge inside the cooldown: no pulse
        send_tick(8'd60, 1'b0, 1'b1);            // exactly the cold threshold
        send_tick(8'd0, 1'b0, 1'b1);

        // Full step drives green straight to the top.
        load_settings('{8'd70, 8'd60, 16'd100, 8'd255, 8'd255}, 1'b0);
        send_tick(8'd255, 1'b0, 1'b1);
        send_tick(8'd255, 1'b0, 1'b1);

        // Zero step with a lowered maximum: ramping up only pulls the level down to
        // the maximum, ramping down leaves it. No cooldown at all.
        load_settings('{8'd70, 8'd60, 16'd0, 8'd0, 8'd100}, 1'b1);
        send_tick(8'd255, 1'b0, 1'b1);
        send_tick(8'd255, 1'b1, 1'b1);
        send_tick(8'd255, 1'b0, 1'b1);
        send_tick(8'd255, 1'b1, 1'b1);

        // Inverted thresholds and a zero maximum.
        load_settings('{8'd0, 8'd255, 16'd0, 8'd255, 8'd0}, 1'b0);
        send_tick(8'd0, 1'b1, 1'b1);
        send_tick(8'd0, 1'b0, 1'b1);
        send_tick(8'd255, 1'b1, 1'b1);
        send_tick(8'd128, 1'b0, 1'b1);

        // Start a cooldown, then lower the limit beneath the running count.
        load_settings('{8'd70, 8'd60, 16'd100, 8'd1, 8'd255}, 1'b0);
        send_tick(8'd0, 1'b0, 1'b1);
        send_tick(8'd0, 1'b1, 1'b1);
        send_tick(8'd0, 1'b0, 1'b1);
        send_tick(8'd0, 1'b0, 1'b1);
        load_settings('{8'd70, 8'd60, 16'd2, 8'd1, 8'd255}, 1'b0);
        send_tick(8'd0, 1'b1, 1'b1);

        // Random phases, each under its own settings. The first three are the corners.
        for (int p = 0; p < PhaseCount; p++) begin
            case (p)
                0:       c = '{8'd0, 8'd0, 16'd0, 8'd1, 8'd255};
                1:       c = '{8'd255, 8'd255, 16'hFFFF, 8'd255, 8'd255};
                2:       c = '{8'd255, 8'd0, 16'd3, 8'd255, 8'd0};
                default: c = random_setting();
            endcase
            load_settings(c, p == PhaseCount - 1);
            steady <= (p == SteadyPhase);

            for (int n = 0; n < PhaseTicks; n++) begin
                // Temperatures mostly hover around the thresholds; the cam switch
                // holds for a while between toggles; hold ticks are sprinkled in.
                pick = $urandom_range(9);
                if (pick < 5) begin
                    temp = near(warm_set);
                end else if (pick < 8) begin
                    temp = near(cold_set);
                end else begin
                    temp = 8'($urandom);
                end
                if ($urandom_range(99) < 30) begin
                    cam_level = !cam_level;
                end
                send_tick(temp, cam_level, $urandom_range(9) != 0);

                // Now and then the sender waits for the block to drain completely.
                if ($urandom_range(49) == 0) begin
                    settle();
                end
            end
        end

        steady <= 1'b0;
        settle();
        // Wait on to catch any stray result.
        repeat (8) @(negedge clk);

        if (mismatches == 0) begin
            $display("tb_indicator_pulse_and_led_ramp: clean");
        end else begin
            $display("tb_indicator_pulse_and_led_ramp: errors");
        end
        $finish;
    end

endmodule
